// File: rtl/core/scbt_pkg.sv
`timescale 1ns / 1ps
package scbt_pkg;

	localparam int MAX_VARS    = 256;
	localparam int MAX_ENTRIES = 4096;
	localparam int BIAS_BITS   = 32;

	localparam int VAR_W  = $clog2(MAX_VARS);
	localparam int ROWC_W = VAR_W + 1;
	localparam int ENT_AW = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = ENT_AW + 1;

	typedef enum logic [2:0] {
		MODE_ADD_ROW = 3'd0,
		MODE_ADD_NB  = 3'd1,
		MODE_GET_LIN = 3'd2,
		MODE_SET_LIN = 3'd3,
		MODE_GET_CPL = 3'd4,
		MODE_SET_CPL = 3'd5,
		MODE_DEGREE  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAME  = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RS0,
		S_RS1,
		S_RS2,
		S_CHK,
		S_BS,
		S_BSW,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]     start;
		logic [BIAS_BITS-1:0] lin;
	} row_word_t;

	typedef struct packed {
		logic [VAR_W-1:0]     nb;
		logic [BIAS_BITS-1:0] cb;
	} entry_word_t;

endpackage

// File: rtl/core/sparse_csr_bias_table.sv
`timescale 1ns / 1ps
// channel   ports                                   handshake
// command   mode, var_u, var_v, bias_in             start high while busy low
// result    bias_out, found, degree_out, status     done high for one cycle
//
// add row, add neighbour, unused mode and any error: done raised from state S_DEC
// linear get/set: S_DEC, S_RS0, S_RS1; degree adds S_RS2 (if a next row) and S_CHK
// coupling get: row reads, then a binary search; coupling set repeats it in the
// mirror row after a hit; single entry read port: each probe uses S_BS and S_BSW
// reset clears state, done, row and entry counts; memories need no clearing pass
// busy stays high from the accepting edge until done; done cannot be held off
module sparse_csr_bias_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     mode,
	input  logic [scbt_pkg::VAR_W-1:0]     var_u,
	input  logic [scbt_pkg::VAR_W-1:0]     var_v,
	input  logic [scbt_pkg::BIAS_BITS-1:0] bias_in,
	output logic                           done,
	output logic [scbt_pkg::BIAS_BITS-1:0] bias_out,
	output logic                           found,
	output logic [scbt_pkg::CNT_W-1:0]     degree_out,
	output logic [1:0]                     status
);
	import scbt_pkg::*;

	state_t                state_q, state_d;
	logic [ROWC_W-1:0]     row_count_q, row_count_d;
	logic [CNT_W-1:0]      entry_count_q, entry_count_d;
	logic                  done_q, done_d;

	logic [2:0]            mode_q, mode_d;
	logic [VAR_W-1:0]      u_q, u_d, v_q, v_d, r_q, r_d, t_q, t_d;
	logic [BIAS_BITS-1:0]  b_q, b_d;
	logic [CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d, end_q, end_d, mid_q, mid_d;
	logic                  second_q, second_d;
	logic [BIAS_BITS-1:0]  bias_q, bias_d;
	logic                  found_q, found_d;
	logic [CNT_W-1:0]      deg_q, deg_d;
	status_t               status_q, status_d;

	logic                  row_we;
	logic [VAR_W-1:0]      row_waddr, row_raddr;
	row_word_t             row_wdata, row_rdata;
	logic                  ent_we;
	logic [ENT_AW-1:0]     ent_waddr, ent_raddr;
	entry_word_t           ent_wdata, ent_rdata;

	logic                  u_bad, v_bad, next_row_in;
	logic [ROWC_W-1:0]     r_next;
	logic [CNT_W-1:0]      mid_w;

	scbt_ram #(.DEPTH(MAX_VARS), .WIDTH($bits(row_word_t))) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	scbt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH($bits(entry_word_t))) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign u_bad       = {1'b0, u_q} >= row_count_q;
	assign v_bad       = {1'b0, v_q} >= row_count_q;
	assign r_next      = {1'b0, r_q} + ROWC_W'(1);
	assign next_row_in = r_next < row_count_q;
	assign mid_w       = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		state_d       = state_q;
		row_count_d   = row_count_q;
		entry_count_d = entry_count_q;
		done_d        = 1'b0;
		mode_d        = mode_q;
		u_d           = u_q;
		v_d           = v_q;
		b_d           = b_q;
		r_d           = r_q;
		t_d           = t_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		end_d         = end_q;
		mid_d         = mid_q;
		second_d      = second_q;
		bias_d        = bias_q;
		found_d       = found_q;
		deg_d         = deg_q;
		status_d      = status_q;
		row_we        = 1'b0;
		row_waddr     = r_q;
		row_wdata     = '{start: entry_count_q, lin: b_q};
		row_raddr     = r_q;
		ent_we        = 1'b0;
		ent_waddr     = lo_q[ENT_AW-1:0];
		ent_wdata     = '{nb: ent_rdata.nb, cb: b_q};
		ent_raddr     = lo_q[ENT_AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_d   = mode;
					u_d      = var_u;
					v_d      = var_v;
					b_d      = bias_in;
					bias_d   = '0;
					found_d  = 1'b0;
					deg_d    = '0;
					status_d = ST_OK;
					second_d = 1'b0;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				case (mode_q)
					MODE_ADD_ROW: begin
						if (row_count_q == ROWC_W'(MAX_VARS)) begin
							status_d = ST_FULL;
						end else begin
							row_we      = 1'b1;
							row_waddr   = row_count_q[VAR_W-1:0];
							row_count_d = row_count_q + ROWC_W'(1);
						end
					end
					MODE_ADD_NB: begin
						if (row_count_q == '0) begin
							status_d = ST_RANGE;
						end else if (entry_count_q == CNT_W'(MAX_ENTRIES)) begin
							status_d = ST_FULL;
						end else if ({1'b0, u_q} == row_count_q - ROWC_W'(1)) begin
							status_d = ST_SAME;
						end else begin
							ent_we        = 1'b1;
							ent_waddr     = entry_count_q[ENT_AW-1:0];
							ent_wdata     = '{nb: u_q, cb: b_q};
							entry_count_d = entry_count_q + CNT_W'(1);
						end
					end
					MODE_GET_LIN, MODE_SET_LIN, MODE_DEGREE: begin
						if (u_bad) begin
							status_d = ST_RANGE;
						end else begin
							r_d     = u_q;
							state_d = S_RS0;
							done_d  = 1'b0;
						end
					end
					MODE_GET_CPL, MODE_SET_CPL: begin
						if (u_bad || v_bad) begin
							status_d = ST_RANGE;
						end else if (u_q == v_q) begin
							status_d = ST_SAME;
						end else begin
							if (mode_q == MODE_GET_CPL && v_q < u_q) begin
								r_d = v_q;
								t_d = u_q;
							end else begin
								r_d = u_q;
								t_d = v_q;
							end
							state_d = S_RS0;
							done_d  = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			S_RS0: begin
				state_d = S_RS1;
			end
			S_RS1: begin
				case (mode_q)
					MODE_GET_LIN: begin
						bias_d  = row_rdata.lin;
						state_d = S_IDLE;
						done_d  = 1'b1;
					end
					MODE_SET_LIN: begin
						row_we    = 1'b1;
						row_wdata = '{start: row_rdata.start, lin: b_q};
						state_d   = S_IDLE;
						done_d    = 1'b1;
					end
					default: begin
						lo_d = row_rdata.start;
						if (next_row_in) begin
							row_raddr = r_next[VAR_W-1:0];
							state_d   = S_RS2;
						end else begin
							hi_d    = entry_count_q;
							state_d = S_CHK;
						end
					end
				endcase
			end
			S_RS2: begin
				hi_d    = row_rdata.start;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (mode_q == MODE_DEGREE) begin
					deg_d   = (hi_q >= lo_q) ? hi_q - lo_q : '0;
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else if (hi_q < lo_q || hi_q > entry_count_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					end_d   = hi_q;
					state_d = S_BS;
				end
			end
			S_BS: begin
				if (lo_q < hi_q) begin
					ent_raddr = mid_w[ENT_AW-1:0];
					mid_d     = mid_w;
					state_d   = S_BSW;
				end else if (lo_q < end_q) begin
					state_d = S_FIN;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_BSW: begin
				if (ent_rdata.nb < t_q) begin
					lo_d = mid_q + CNT_W'(1);
				end else begin
					hi_d = mid_q;
				end
				state_d = S_BS;
			end
			S_FIN: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (ent_rdata.nb == t_q) begin
					found_d = 1'b1;
					if (mode_q == MODE_GET_CPL) begin
						bias_d = ent_rdata.cb;
					end else begin
						ent_we = 1'b1;
						if (!second_q) begin
							second_d = 1'b1;
							r_d      = v_q;
							t_d      = u_q;
							state_d  = S_RS0;
							done_d   = 1'b0;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			row_count_q   <= '0;
			entry_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			row_count_q   <= row_count_d;
			entry_count_q <= entry_count_d;
			done_q        <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q   <= mode_d;
		u_q      <= u_d;
		v_q      <= v_d;
		b_q      <= b_d;
		r_q      <= r_d;
		t_q      <= t_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		end_q    <= end_d;
		mid_q    <= mid_d;
		second_q <= second_d;
		bias_q   <= bias_d;
		found_q  <= found_d;
		deg_q    <= deg_d;
		status_q <= status_d;
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign bias_out   = bias_q;
	assign found      = found_q;
	assign degree_out = deg_q;
	assign status     = status_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without a word in progress");

	a_row_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= ROWC_W'(MAX_VARS))
		else $error("row count beyond table size");

	a_entry_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BS) |-> (lo_q <= hi_q && hi_q <= end_q))
		else $error("search window inverted");

endmodule

// File: rtl/core/scbt_ram.sv
`timescale 1ns / 1ps
module scbt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import scbt_pkg::*;

	localparam logic [2:0] MODE_NONE = 3'd7;
	localparam int BUILD_ROWS = 60;
	localparam int LONG_ROW = 100;

	typedef struct {
		logic [BIAS_BITS-1:0] bias;
		logic                 found;
		logic [CNT_W-1:0]     degree;
		logic [1:0]           status;
	} reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [2:0]           mode;
	logic [VAR_W-1:0]     var_u;
	logic [VAR_W-1:0]     var_v;
	logic [BIAS_BITS-1:0] bias_in;
	logic                 done;
	logic [BIAS_BITS-1:0] bias_out;
	logic                 found;
	logic [CNT_W-1:0]     degree_out;
	logic [1:0]           status;

	// shadow copy of the table
	logic [CNT_W-1:0]     sh_start [MAX_VARS];
	logic [BIAS_BITS-1:0] sh_lin   [MAX_VARS];
	logic [VAR_W-1:0]     sh_nb    [MAX_ENTRIES];
	logic [BIAS_BITS-1:0] sh_cpl   [MAX_ENTRIES];
	int                   rows;
	int                   ents;

	// planned couplings of the randomly built rows
	bit [MAX_VARS-1:0]    link [MAX_VARS];

	reply_t               pending [$];
	int                   n_fail;
	int                   n_checked;
	int                   n_mode [8];
	bit                   calm;
	int                   gap_odds;

	sparse_csr_bias_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.var_u      (var_u),
		.var_v      (var_v),
		.bias_in    (bias_in),
		.done       (done),
		.bias_out   (bias_out),
		.found      (found),
		.degree_out (degree_out),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int row_limit(int r);
		return (r + 1 < rows) ? int'(sh_start[r + 1]) : ents;
	endfunction

	// lower-bound search of row r, then an equality check on the hit
	function automatic int row_lookup(int r, int target);
		int lo;
		int hi;
		int stop;
		int mid;
		lo = int'(sh_start[r]);
		hi = row_limit(r);
		stop = hi;
		if (hi < lo || hi > ents) begin
			return -1;
		end
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (int'(sh_nb[mid]) < target) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		if (lo < stop && int'(sh_nb[lo]) == target) begin
			return lo;
		end
		return -1;
	endfunction

	function automatic reply_t table_apply(logic [2:0] md, logic [VAR_W-1:0] u,
			logic [VAR_W-1:0] v, logic [BIAS_BITS-1:0] b);
		reply_t r;
		int p;
		int q;
		int s;
		int e;
		r = '{bias: '0, found: 1'b0, degree: '0, status: ST_OK};
		case (md)
			MODE_ADD_ROW: begin
				if (rows >= MAX_VARS) begin
					r.status = ST_FULL;
				end else begin
					sh_start[rows] = CNT_W'(ents);
					sh_lin[rows] = b;
					rows++;
				end
			end
			MODE_ADD_NB: begin
				if (rows == 0) begin
					r.status = ST_RANGE;
				end else if (ents >= MAX_ENTRIES) begin
					r.status = ST_FULL;
				end else if (int'(u) == rows - 1) begin
					r.status = ST_SAME;
				end else begin
					sh_nb[ents] = u;
					sh_cpl[ents] = b;
					ents++;
				end
			end
			MODE_GET_LIN, MODE_SET_LIN, MODE_DEGREE: begin
				if (int'(u) >= rows) begin
					r.status = ST_RANGE;
				end else if (md == MODE_GET_LIN) begin
					r.bias = sh_lin[u];
				end else if (md == MODE_SET_LIN) begin
					sh_lin[u] = b;
				end else begin
					s = int'(sh_start[u]);
					e = row_limit(int'(u));
					r.degree = (e >= s) ? CNT_W'(e - s) : '0;
				end
			end
			MODE_GET_CPL, MODE_SET_CPL: begin
				if (int'(u) >= rows || int'(v) >= rows) begin
					r.status = ST_RANGE;
				end else if (u == v) begin
					r.status = ST_SAME;
				end else if (md == MODE_GET_CPL) begin
					p = (u < v) ? row_lookup(int'(u), int'(v)) : row_lookup(int'(v), int'(u));
					if (p >= 0) begin
						r.found = 1'b1;
						r.bias = sh_cpl[p];
					end
				end else begin
					p = row_lookup(int'(u), int'(v));
					if (p >= 0) begin
						r.found = 1'b1;
						sh_cpl[p] = b;
						q = row_lookup(int'(v), int'(u));
						if (q >= 0) begin
							sh_cpl[q] = b;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [BIAS_BITS-1:0] pick_bias();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cmd(input logic [2:0] md, input logic [VAR_W-1:0] u,
			input logic [VAR_W-1:0] v, input logic [BIAS_BITS-1:0] b);
		if (!calm && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		mode <= md;
		var_u <= u;
		var_v <= v;
		bias_in <= b;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending = {pending, table_apply(md, u, v, b)};
		n_mode[md]++;
	endtask

	task automatic random_query();
		int pick;
		int a;
		int c;
		int k;
		pick = $urandom_range(0, 99);
		a = $urandom_range(0, rows - 1);
		c = $urandom_range(0, rows - 1);
		for (k = 0; k < 8 && !(c != a && link[a][c]); k++) begin
			c = $urandom_range(0, rows - 1);
		end
		if (c == a) begin
			c = (a + 1) % rows;
		end
		if (pick < 30) begin
			send_cmd(MODE_GET_CPL, VAR_W'(a), VAR_W'(c), pick_bias());
		end else if (pick < 55) begin
			send_cmd(MODE_SET_CPL, VAR_W'(a), VAR_W'(c), pick_bias());
		end else if (pick < 65) begin
			send_cmd(MODE_GET_LIN, VAR_W'(a), VAR_W'($urandom()), pick_bias());
		end else if (pick < 75) begin
			send_cmd(MODE_SET_LIN, VAR_W'(a), VAR_W'($urandom()), pick_bias());
		end else if (pick < 85) begin
			send_cmd(MODE_DEGREE, VAR_W'(a), VAR_W'($urandom()), pick_bias());
		end else if (pick < 92) begin
			send_cmd(3'($urandom_range(MODE_GET_LIN, MODE_DEGREE)), VAR_W'($urandom()),
				VAR_W'($urandom()), pick_bias());
		end else if (pick < 96) begin
			send_cmd(MODE_NONE, VAR_W'($urandom()), VAR_W'($urandom()), $urandom());
		end else begin
			send_cmd(($urandom_range(0, 1) == 0) ? MODE_GET_CPL : MODE_SET_CPL,
				VAR_W'(a), VAR_W'(a), pick_bias());
		end
	endtask

	task automatic test_empty_table();
		gap_odds = 2;
		// empty table: every command but the unused mode is out of range
		send_cmd(MODE_ADD_NB, 8'd5, 8'd0, 32'h0000_0001);
		send_cmd(MODE_GET_LIN, 8'd0, 8'd0, 32'h0);
		send_cmd(MODE_DEGREE, 8'd0, 8'd0, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd0, 8'd1, 32'h0);
		send_cmd(MODE_NONE, 8'hff, 8'hff, 32'hffff_ffff);
		// three small rows, row 1 missing its mirror of row 0
		send_cmd(MODE_ADD_ROW, 8'hff, 8'hff, 32'h0000_0000);
		send_cmd(MODE_ADD_NB, 8'd0, 8'd0, 32'h1111_1111);
		send_cmd(MODE_ADD_NB, 8'd1, 8'd0, 32'hffff_ffff);
		send_cmd(MODE_ADD_NB, 8'd255, 8'd0, 32'ha5a5_a5a5);
		send_cmd(MODE_ADD_ROW, 8'd0, 8'd0, 32'hffff_ffff);
		send_cmd(MODE_ADD_NB, 8'd2, 8'd0, 32'h5a5a_5a5a);
		send_cmd(MODE_ADD_ROW, 8'd0, 8'd0, 32'h1234_5678);
		send_cmd(MODE_ADD_NB, 8'd1, 8'd0, 32'h8000_0001);
		send_cmd(MODE_GET_LIN, 8'd1, 8'd0, 32'h0);
		send_cmd(MODE_SET_LIN, 8'd0, 8'd0, 32'hffff_ffff);
		send_cmd(MODE_GET_LIN, 8'd0, 8'd0, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd1, 8'd1, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd0, 8'd2, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd1, 8'd0, 32'h0);
		send_cmd(MODE_SET_CPL, 8'd0, 8'd1, 32'hdead_beef);
		send_cmd(MODE_SET_CPL, 8'd1, 8'd0, 32'h0bad_f00d);
		send_cmd(MODE_SET_CPL, 8'd2, 8'd1, 32'hcafe_0001);
		send_cmd(MODE_GET_CPL, 8'd1, 8'd2, 32'h0);
		send_cmd(MODE_DEGREE, 8'd0, 8'd0, 32'h0);
		send_cmd(MODE_DEGREE, 8'd2, 8'd0, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd0, 8'd3, 32'h0);
		send_cmd(MODE_GET_CPL, 8'd200, 8'd0, 32'h0);
	endtask

	task automatic test_random_build();
		int base;
		int r;
		int j;
		base = rows;
		for (r = base; r < base + BUILD_ROWS; r++) begin
			for (j = r + 1; j < base + BUILD_ROWS; j++) begin
				if ($urandom_range(0, 21) == 0) begin
					link[r][j] = 1'b1;
					link[j][r] = 1'b1;
				end
			end
		end
		for (r = base; r < base + BUILD_ROWS; r++) begin
			gap_odds = $urandom_range(0, 4);
			send_cmd(MODE_ADD_ROW, VAR_W'($urandom()), VAR_W'($urandom()), pick_bias());
			for (j = 0; j < MAX_VARS; j++) begin
				if (link[r][j]) begin
					// occasional self append and out-of-order append
					if ($urandom_range(0, 29) == 0) begin
						send_cmd(MODE_ADD_NB, VAR_W'(r), VAR_W'($urandom()), pick_bias());
					end
					if ($urandom_range(0, 39) == 0) begin
						send_cmd(MODE_ADD_NB, VAR_W'($urandom()), VAR_W'($urandom()),
							pick_bias());
					end
					send_cmd(MODE_ADD_NB, VAR_W'(j), VAR_W'($urandom()), pick_bias());
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				send_cmd(MODE_ADD_NB, VAR_W'($urandom_range(200, 255)), VAR_W'($urandom()),
					pick_bias());
			end
			repeat ($urandom_range(0, 4)) random_query();
		end
	endtask

	task automatic test_fill_rows();
		gap_odds = 3;
		while (rows < MAX_VARS) begin
			send_cmd(MODE_ADD_ROW, VAR_W'($urandom()), VAR_W'($urandom()), pick_bias());
			if (rows < MAX_VARS && $urandom_range(0, 2) == 0) begin
				send_cmd(MODE_ADD_NB, VAR_W'($urandom()), VAR_W'($urandom()), pick_bias());
			end
			if ($urandom_range(0, 3) == 0) begin
				random_query();
			end
		end
		send_cmd(MODE_ADD_ROW, VAR_W'($urandom()), VAR_W'($urandom()), pick_bias());
	endtask

	task automatic test_long_row();
		int k;
		calm = 1'b1;
		// ascending ramp into the last row
		for (k = 0; k < LONG_ROW; k++) begin
			send_cmd(MODE_ADD_NB, VAR_W'((k * (MAX_VARS - 1)) / LONG_ROW),
				VAR_W'($urandom()), pick_bias());
		end
		send_cmd(MODE_ADD_NB, 8'd0, 8'd0, 32'hffff_ffff);
		send_cmd(MODE_ADD_NB, 8'd255, 8'd0, 32'h0);
		send_cmd(MODE_ADD_ROW, 8'd0, 8'd0, 32'h0);
	endtask

	task automatic test_big_row();
		int k;
		send_cmd(MODE_DEGREE, 8'd255, 8'd0, 32'h0);
		repeat (30) begin
			k = $urandom_range(0, MAX_VARS - 2);
			send_cmd(MODE_SET_CPL, 8'd255, VAR_W'(k), pick_bias());
			send_cmd(MODE_SET_CPL, VAR_W'(k), 8'd255, pick_bias());
			send_cmd(MODE_GET_CPL, VAR_W'(k), 8'd255, 32'h0);
		end
		repeat (40) random_query();
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			n_checked++;
			if (pending.size() == 0) begin
				$error("result word with nothing pending: bias_out %h status %0d",
					bias_out, status);
				n_fail++;
			end else begin
				want = pending.pop_front();
				if (bias_out !== want.bias) begin
					$error("bias_out: expected %h, got %h", want.bias, bias_out);
					n_fail++;
				end
				if (found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, found);
					n_fail++;
				end
				if (degree_out !== want.degree) begin
					$error("degree_out: expected %0d, got %0d", want.degree, degree_out);
					n_fail++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_fail++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		var_u = '0;
		var_v = '0;
		bias_in = '0;
		calm = 1'b0;
		gap_odds = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_random_build();
		test_fill_rows();
		test_long_row();
		test_big_row();
		start <= 1'b0;

		guard = 0;
		while (pending.size() > 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (pending.size() > 0) begin
			$error("%0d result words never arrived", pending.size());
			n_fail++;
		end

		$display("sent %0d appends, %0d coupling get/set, %0d linear/degree, %0d unused mode",
			n_mode[MODE_ADD_ROW] + n_mode[MODE_ADD_NB],
			n_mode[MODE_GET_CPL] + n_mode[MODE_SET_CPL],
			n_mode[MODE_GET_LIN] + n_mode[MODE_SET_LIN] + n_mode[MODE_DEGREE],
			n_mode[MODE_NONE]);
		$display("table filled to %0d rows / %0d entries, %0d result words checked",
			rows, ents, n_checked);
		if (n_fail == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/scbt_pkg.sv
rtl/core/scbt_ram.sv
rtl/core/sparse_csr_bias_table.sv
dv/tb_top.sv
